// ===== hw/rtl/rks_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Rabbit keystream package
// Shared types, constants and helper functions for the keystream cipher.
// ----------------------------------------------------------------------------
package rks_pkg;

  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int CFG_INDEX_W     = 2;
  localparam int CFG_DATA_W      = 64;
  localparam int BLOCK_W         = 128;
  localparam int BYTES_PER_BLOCK = 16;
  localparam int ADV_PHASES      = 11;
  localparam logic [3:0] PHASE_LAST = 4'(ADV_PHASES - 1);

  localparam logic KIND_SETUP = 1'b0;
  localparam logic KIND_DATA  = 1'b1;

  typedef enum logic [1:0] {
    CFG_KEY_LOW   = 2'd0,
    CFG_KEY_HIGH  = 2'd1,
    CFG_IV_VALUE  = 2'd2,
    CFG_IV_ENABLE = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KEY_ADV,
    ST_MIX,
    ST_IV_ADV,
    ST_BLK_ADV
  } eng_state_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic       raw_keystream;
    logic       last_of_message;
  } req_item_t;

  typedef struct packed {
    logic setup_req;
    logic take;
  } eng_req_t;

  typedef struct packed {
    logic               setup_ack;
    logic               blk_valid;
    logic [BLOCK_W-1:0] blk;
  } eng_rsp_t;

  function automatic logic [31:0] ctr_add(input logic [2:0] idx);
    logic [31:0] v;
    case (idx)
      3'd0, 3'd3, 3'd6: v = 32'h4D34D34D;
      3'd1, 3'd4, 3'd7: v = 32'hD34D34D3;
      3'd2, 3'd5:       v = 32'h34D34D34;
      default:          v = 32'h4D34D34D;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] rotl16(input logic [31:0] v);
    return {v[15:0], v[31:16]};
  endfunction

  function automatic logic [31:0] rotl8(input logic [31:0] v);
    return {v[23:0], v[31:24]};
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/rabbit_keystream_cipher.sv =====
`default_nettype none
// Data path: a data request is queued, then issued when a block is ready and its result registered.
// Throughput: 1 byte per cycle when the output does not stall; the next block is prefetched once the last is taken.
// Setup request: acknowledged in idle, then key rounds, a mix step and (with IV) IV rounds in the engine, no result.
// Blocks are prefetched; one 32x32 squarer, shared by all eight words, sets the pace of each advance.
// Reset (rst, synchronous): state and counters zero, block exhausted, prefetch starts.
// ----------------------------------------------------------------------------
// Rabbit keystream cipher
// Top level: request queue, keystream engine and byte back end.
// ----------------------------------------------------------------------------
module rabbit_keystream_cipher import rks_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic                   kind,
  input  wire logic [7:0]             data_byte,
  input  wire logic                   raw_keystream,
  input  wire logic                   last_of_message,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [7:0]                  out_byte,
  output logic                        out_last,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  req_item_t in_item;
  req_item_t head;
  logic      head_valid;
  logic      pop;
  logic      full;
  eng_req_t  req;
  eng_rsp_t  rsp;

  assign in_item.kind            = kind;
  assign in_item.data_byte       = data_byte;
  assign in_item.raw_keystream   = raw_keystream;
  assign in_item.last_of_message = last_of_message;
  assign in_stall  = full;
  assign cfg_ready = 1'b1;

  rks_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (in_valid),
    .push_item  (in_item),
    .full       (full),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  rks_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .rsp       (rsp)
  );

  rks_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .req        (req),
    .rsp        (rsp),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .out_last   (out_last)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/rks_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Rabbit keystream request queue
// Front part: accepts requests and holds them for the back end.
// ----------------------------------------------------------------------------
module rks_queue import rks_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire req_item_t push_item,
  output logic           full,
  output logic           head_valid,
  output req_item_t      head,
  input  wire logic      pop
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  req_item_t        mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full       = (count == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(do_push) - CNT_W'(do_pop);
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/rks_engine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Rabbit keystream engine
// Holds cipher state, runs key/IV setup and prefetches keystream blocks.
// ----------------------------------------------------------------------------
module rks_engine import rks_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire eng_req_t               req,
  output eng_rsp_t                    rsp
);

  logic [63:0] key_low;
  logic [63:0] key_high;
  logic [63:0] iv_value;
  logic        iv_enable;

  eng_state_t  state;
  eng_state_t  state_next;
  logic [3:0]  phase;
  logic [1:0]  rounds;
  logic        blk_valid;
  logic [BLOCK_W-1:0] blk;

  logic [31:0] x [8];
  logic [31:0] c [8];
  logic [31:0] g [8];
  logic        carry;
  logic [31:0] t;
  logic [63:0] sq;

  logic        adv;
  logic        adv_end;
  logic        setup_ack;
  logic [2:0]  idx;
  logic [2:0]  gidx;
  logic [32:0] csum;
  logic [31:0] newx [8];
  logic [31:0] ivw [8];
  logic [31:0] k0, k1, k2, k3, i0, i1, i2, i3;

  assign k0 = key_low[31:0];
  assign k1 = key_low[63:32];
  assign k2 = key_high[31:0];
  assign k3 = key_high[63:32];
  assign i0 = iv_value[31:0];
  assign i2 = iv_value[63:32];
  assign i1 = {i2[31:16], i0[31:16]};
  assign i3 = {i2[15:0], i0[15:0]};

  assign adv = (state == ST_KEY_ADV) || (state == ST_IV_ADV) || (state == ST_BLK_ADV);
  assign adv_end   = adv && (phase == PHASE_LAST);
  assign setup_ack = (state == ST_IDLE) && req.setup_req;
  assign idx  = phase[2:0];
  assign gidx = 3'(phase - 4'd2);
  assign csum = {1'b0, c[idx]} + {1'b0, ctr_add(idx)} + {32'b0, carry};

  always_comb begin
    newx[0] = g[0] + rotl16(g[7]) + rotl16(g[6]);
    newx[1] = g[1] + rotl8(g[0])  + g[7];
    newx[2] = g[2] + rotl16(g[1]) + rotl16(g[0]);
    newx[3] = g[3] + rotl8(g[2])  + g[1];
    newx[4] = g[4] + rotl16(g[3]) + rotl16(g[2]);
    newx[5] = g[5] + rotl8(g[4])  + g[3];
    newx[6] = g[6] + rotl16(g[5]) + rotl16(g[4]);
    newx[7] = g[7] + rotl8(g[6])  + g[5];
    ivw[0] = i0; ivw[1] = i1; ivw[2] = i2; ivw[3] = i3;
    ivw[4] = i0; ivw[5] = i1; ivw[6] = i2; ivw[7] = i3;
  end

  assign rsp.setup_ack = setup_ack;
  assign rsp.blk_valid = blk_valid;
  assign rsp.blk       = blk;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req.setup_req) begin
          state_next = ST_KEY_ADV;
        end else if (!blk_valid) begin
          state_next = ST_BLK_ADV;
        end
      end
      ST_KEY_ADV: begin
        if (adv_end && rounds == 2'd0) state_next = ST_MIX;
      end
      ST_MIX: begin
        state_next = iv_enable ? ST_IV_ADV : ST_IDLE;
      end
      ST_IV_ADV: begin
        if (adv_end && rounds == 2'd0) state_next = ST_IDLE;
      end
      ST_BLK_ADV: begin
        if (adv_end) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_low   <= '0;
      key_high  <= '0;
      iv_value  <= '0;
      iv_enable <= 1'b1;
    end else if (cfg_write) begin
      case (cfg_reg_e'(cfg_index))
        CFG_KEY_LOW:   key_low   <= cfg_data;
        CFG_KEY_HIGH:  key_high  <= cfg_data;
        CFG_IV_VALUE:  iv_value  <= cfg_data;
        CFG_IV_ENABLE: iv_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= '0;
      rounds    <= '0;
      blk_valid <= 1'b0;
      carry     <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        x[i] <= '0;
        c[i] <= '0;
      end
    end else begin
      phase <= (adv && !adv_end) ? phase + 4'd1 : 4'd0;
      if (setup_ack || state == ST_MIX) begin
        rounds <= 2'd3;
      end else if (adv_end) begin
        rounds <= rounds - 2'd1;
      end
      if (setup_ack || req.take) begin
        blk_valid <= 1'b0;
      end else if (state == ST_BLK_ADV && adv_end) begin
        blk_valid <= 1'b1;
      end
      if (setup_ack) begin
        x[0] <= k0;
        x[2] <= k1;
        x[4] <= k2;
        x[6] <= k3;
        x[1] <= {k3[15:0], k2[31:16]};
        x[3] <= {k0[15:0], k3[31:16]};
        x[5] <= {k1[15:0], k0[31:16]};
        x[7] <= {k2[15:0], k1[31:16]};
        c[0] <= rotl16(k2);
        c[2] <= rotl16(k3);
        c[4] <= rotl16(k0);
        c[6] <= rotl16(k1);
        c[1] <= {k0[31:16], k1[15:0]};
        c[3] <= {k1[31:16], k2[15:0]};
        c[5] <= {k2[31:16], k3[15:0]};
        c[7] <= {k3[31:16], k0[15:0]};
        carry <= 1'b0;
      end else if (state == ST_MIX) begin
        for (int i = 0; i < 8; i++) begin
          c[i] <= c[i] ^ x[(i + 4) % 8] ^ (iv_enable ? ivw[i] : 32'h0);
        end
      end else if (adv) begin
        if (phase < 4'd8) begin
          c[idx] <= csum[31:0];
          carry  <= csum[32];
        end
        if (adv_end) begin
          for (int i = 0; i < 8; i++) begin
            x[i] <= newx[i];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    t  <= x[idx] + csum[31:0];
    sq <= {32'h0, t} * {32'h0, t};
    if (adv && phase >= 4'd2 && phase <= 4'd9) begin
      g[gidx] <= sq[31:0] ^ sq[63:32];
    end
    if (state == ST_BLK_ADV && adv_end) begin
      blk <= {newx[6] ^ (newx[3] >> 16) ^ (newx[1] << 16),
              newx[4] ^ (newx[1] >> 16) ^ (newx[7] << 16),
              newx[2] ^ (newx[7] >> 16) ^ (newx[5] << 16),
              newx[0] ^ (newx[5] >> 16) ^ (newx[3] << 16)};
    end
  end

`ifndef ASSERT_OFF
  a_blk_from_adv: assert property (@(posedge clk) disable iff (rst)
    $rose(blk_valid) |-> $past(state) == ST_BLK_ADV)
    else $error("block valid without block advance");
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    phase <= PHASE_LAST)
    else $error("advance phase out of range");
  a_setup_start: assert property (@(posedge clk) disable iff (rst)
    setup_ack |=> state == ST_KEY_ADV && !blk_valid && phase == 4'd0)
    else $error("setup did not start key rounds");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/rks_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Rabbit keystream back end
// Pops requests, selects keystream bytes and drives the result register.
// ----------------------------------------------------------------------------
module rks_back import rks_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      head_valid,
  input  wire req_item_t head,
  output logic           pop,
  output eng_req_t       req,
  input  wire eng_rsp_t  rsp,
  output logic           out_valid,
  input  wire logic      out_stall,
  output logic [7:0]     out_byte,
  output logic           out_last
);

  logic [4:0]         pos;
  logic [BLOCK_W-1:0] cur;
  logic               load;
  logic               exhausted;
  logic               issue;
  logic               take;
  logic [7:0]         ks;

  assign load      = !out_valid || !out_stall;
  assign exhausted = pos[4];
  assign issue     = head_valid && (head.kind == KIND_DATA) && load &&
                     (!exhausted || rsp.blk_valid);
  assign take      = issue && exhausted;
  assign ks        = take ? rsp.blk[7:0] : cur[{pos[3:0], 3'b000} +: 8];

  assign req.setup_req = head_valid && (head.kind == KIND_SETUP);
  assign req.take      = take;
  assign pop           = issue || rsp.setup_ack;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pos       <= 5'(BYTES_PER_BLOCK);
    end else begin
      if (load) begin
        out_valid <= issue;
      end
      if (rsp.setup_ack) begin
        pos <= 5'(BYTES_PER_BLOCK);
      end else if (take) begin
        pos <= 5'd1;
      end else if (issue) begin
        pos <= pos + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      out_byte <= head.raw_keystream ? ks : (ks ^ head.data_byte);
      out_last <= head.last_of_message;
    end
    if (take) begin
      cur <= rsp.blk;
    end
  end

`ifndef ASSERT_OFF
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos <= 5'(BYTES_PER_BLOCK))
    else $error("byte position out of range");
  a_setup_exhausts: assert property (@(posedge clk) disable iff (rst)
    rsp.setup_ack |=> pos == 5'(BYTES_PER_BLOCK))
    else $error("setup left block in use");
  a_take_restart: assert property (@(posedge clk) disable iff (rst)
    take |=> pos == 5'd1 && out_valid)
    else $error("block take did not restart position");
`endif

endmodule
`default_nettype wire

// ===== tb/tb_rabbit_keystream_cipher.sv =====
// ----------------------------------------------------------------------------
// Rabbit keystream cipher testbench
// Drives setup and byte requests with random gaps and output stalls, rewrites
// the key, IV and IV enable registers between phases, and checks every output
// byte against an in-bench cipher predictor.
// ----------------------------------------------------------------------------
module tb_rabbit_keystream_cipher import rks_pkg::*;;

  class keystream_scoreboard;
    bit [31:0] x_words[8];
    bit [31:0] c_words[8];
    bit        carry;
    bit [31:0] ks_words[4];
    int unsigned pos;
    bit [63:0] key_lo, key_hi, iv;
    bit        iv_on;
    bit [8:0]  expected_bytes[$];
    int unsigned mismatches;
    bit [31:0] step_add[8] = '{32'h4D34D34D, 32'hD34D34D3, 32'h34D34D34, 32'h4D34D34D,
                               32'hD34D34D3, 32'h34D34D34, 32'h4D34D34D, 32'hD34D34D3};

    function new();
      pos = 16;
      iv_on = 1'b1;
    endfunction

    function bit [31:0] rot(bit [31:0] v, int r);
      return (v << r) | (v >> (32 - r));
    endfunction

    function bit [31:0] square_mix(bit [31:0] xv, bit [31:0] cv);
      bit [31:0] t;
      bit [63:0] sq;
      t = xv + cv;
      sq = {32'b0, t} * {32'b0, t};
      return sq[31:0] ^ sq[63:32];
    endfunction

    function void advance_state();
      bit [32:0] s;
      bit [31:0] g[8];
      for (int i = 0; i < 8; i++) begin
        s = {1'b0, c_words[i]} + {1'b0, step_add[i]} + {32'b0, carry};
        c_words[i] = s[31:0];
        carry = s[32];
      end
      for (int i = 0; i < 8; i++) g[i] = square_mix(x_words[i], c_words[i]);
      x_words[0] = g[0] + rot(g[7], 16) + rot(g[6], 16);
      x_words[1] = g[1] + rot(g[0], 8) + g[7];
      x_words[2] = g[2] + rot(g[1], 16) + rot(g[0], 16);
      x_words[3] = g[3] + rot(g[2], 8) + g[1];
      x_words[4] = g[4] + rot(g[3], 16) + rot(g[2], 16);
      x_words[5] = g[5] + rot(g[4], 8) + g[3];
      x_words[6] = g[6] + rot(g[5], 16) + rot(g[4], 16);
      x_words[7] = g[7] + rot(g[6], 8) + g[5];
    endfunction

    function void write_reg(cfg_reg_e idx, bit [63:0] value);
      case (idx)
        CFG_KEY_LOW:   key_lo = value;
        CFG_KEY_HIGH:  key_hi = value;
        CFG_IV_VALUE:  iv = value;
        CFG_IV_ENABLE: iv_on = value[0];
        default: ;
      endcase
    endfunction

    function void key_setup();
      bit [31:0] k0, k1, k2, k3, i0, i1, i2, i3;
      k0 = key_lo[31:0];
      k1 = key_lo[63:32];
      k2 = key_hi[31:0];
      k3 = key_hi[63:32];
      x_words = '{k0, {k3[15:0], k2[31:16]}, k1, {k0[15:0], k3[31:16]},
                  k2, {k1[15:0], k0[31:16]}, k3, {k2[15:0], k1[31:16]}};
      c_words = '{rot(k2, 16), {k0[31:16], k1[15:0]}, rot(k3, 16), {k1[31:16], k2[15:0]},
                  rot(k0, 16), {k2[31:16], k3[15:0]}, rot(k1, 16), {k3[31:16], k0[15:0]}};
      carry = 1'b0;
      repeat (4) advance_state();
      for (int i = 0; i < 8; i++) c_words[i] ^= x_words[(i + 4) % 8];
      if (iv_on) begin
        i0 = iv[31:0];
        i2 = iv[63:32];
        i1 = {i2[31:16], i0[31:16]};
        i3 = {i2[15:0], i0[15:0]};
        for (int i = 0; i < 8; i += 4) begin
          c_words[i] ^= i0;
          c_words[i + 1] ^= i1;
          c_words[i + 2] ^= i2;
          c_words[i + 3] ^= i3;
        end
        repeat (4) advance_state();
      end
      pos = 16;
    endfunction

    function void note_request(bit k, bit [7:0] d, bit raw, bit last);
      bit [7:0] ks;
      if (k == KIND_SETUP) begin
        key_setup();
        return;
      end
      if (pos >= 16) begin
        advance_state();
        ks_words[0] = x_words[0] ^ (x_words[5] >> 16) ^ (x_words[3] << 16);
        ks_words[1] = x_words[2] ^ (x_words[7] >> 16) ^ (x_words[5] << 16);
        ks_words[2] = x_words[4] ^ (x_words[1] >> 16) ^ (x_words[7] << 16);
        ks_words[3] = x_words[6] ^ (x_words[3] >> 16) ^ (x_words[1] << 16);
        pos = 0;
      end
      ks = 8'(ks_words[pos / 4] >> (8 * (pos % 4)));
      pos++;
      expected_bytes.push_back({last, raw ? ks : ks ^ d});
    endfunction

    function void check_byte(bit [7:0] b, bit last);
      bit [8:0] e;
      if (expected_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output byte %h last %b", b, last);
        return;
      end
      e = expected_bytes.pop_front();
      if (e != {last, b}) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected byte %h last %b, actual byte %h last %b",
                   e[7:0], e[8], b, last);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic in_valid, in_stall, kind, raw_keystream, last_of_message;
  logic [7:0] data_byte;
  logic out_valid, out_stall, out_last;
  logic [7:0] out_byte;
  logic cfg_valid, cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  keystream_scoreboard sb = new();
  bit quiet;
  int unsigned sent;
  int unsigned stall_left;

  rabbit_keystream_cipher dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_byte(out_byte, out_last);
    if (quiet || rst) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 5);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_request(bit k, bit [7:0] d, bit raw, bit last);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    data_byte <= d;
    raw_keystream <= raw;
    last_of_message <= last;
    do @(posedge clk); while (in_stall);
    sb.note_request(k, d, raw, last);
    sent++;
  endtask

  task automatic send_random_byte();
    send_request(KIND_DATA, 8'($urandom), $urandom_range(0, 3) == 0, $urandom_range(0, 7) == 0);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_bytes.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_e idx, bit [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, value);
    cfg_valid <= 1'b0;
  endtask

  function automatic bit [63:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 64'h0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic reconfigure();
    drain();
    write_reg(CFG_KEY_LOW, pick_value());
    write_reg(CFG_KEY_HIGH, pick_value());
    write_reg(CFG_IV_VALUE, pick_value());
    write_reg(CFG_IV_ENABLE, 64'($urandom_range(0, 1)));
  endtask

  initial begin
    int n;
    rst <= 1'b1;
    in_valid <= 1'b0;
    kind <= KIND_DATA;
    data_byte <= '0;
    raw_keystream <= 1'b0;
    last_of_message <= 1'b0;
    out_stall <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_KEY_LOW;
    cfg_data <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_request(KIND_DATA, 8'h00, 1'b1, 1'b0);
    send_request(KIND_DATA, 8'hFF, 1'b0, 1'b1);
    send_request(KIND_DATA, 8'h00, 1'b0, 1'b0);
    drain();
    write_reg(CFG_KEY_LOW, '1);
    write_reg(CFG_KEY_HIGH, '1);
    write_reg(CFG_IV_VALUE, '1);
    write_reg(CFG_IV_ENABLE, 64'd1);
    send_request(KIND_SETUP, 8'h00, 1'b0, 1'b0);
    for (int i = 0; i < 17; i++)
      send_request(KIND_DATA, (i % 2) ? 8'hFF : 8'h00, i % 3 == 0, i == 16);
    drain();
    write_reg(CFG_KEY_LOW, '0);
    write_reg(CFG_KEY_HIGH, '0);
    write_reg(CFG_IV_VALUE, '0);
    write_reg(CFG_IV_ENABLE, 64'd0);
    send_request(KIND_SETUP, 8'hFF, 1'b1, 1'b1);
    send_request(KIND_SETUP, 8'h00, 1'b0, 1'b0);
    send_request(KIND_DATA, 8'hA5, 1'b0, 1'b1);

    while (sent < 1750) begin
      if ($urandom_range(0, 2) == 0) reconfigure();
      if (sent > 1550) quiet = 1'b1;
      send_request(KIND_SETUP, 8'($urandom), $urandom_range(0, 1), $urandom_range(0, 1));
      n = $urandom_range(5, 120);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 39) == 0)
          send_request(KIND_SETUP, 8'($urandom), $urandom_range(0, 1), $urandom_range(0, 1));
        else
          send_random_byte();
      end
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_bytes.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_bytes.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
